FILE: rtl/kt_pkg.sv
package kt_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 10;
  localparam int KEY_BYTES   = 8;

  localparam int KEY_W  = 64;
  localparam int AMT_W  = 32;
  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

  // bytes above KEY_BYTES are cleared before storing or comparing
  localparam logic [KEY_W-1:0] KEY_MASK = (KEY_BYTES >= 8) ? {KEY_W{1'b1}} :
    ((KEY_W'(1) << (8 * KEY_BYTES)) - KEY_W'(1));

  // request codes
  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_LIST   = 2'd2;
  localparam logic [1:0] REQ_SEARCH = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  // one table entry as kept in memory
  typedef struct packed {
    logic [KEY_W-1:0]        name;
    logic [KEY_W-1:0]        kind;
    logic signed [AMT_W-1:0] amount;
  } entry_t;

endpackage

FILE: rtl/keyed_table_insert_remove_search.sv
// channel | handshake            | payload
// in      | in_valid / in_stall  | req_type, name_key, kind_key, amount
// out     | out_valid / out_stall| status, found_name, found_kind, found_amount, last
//
// one request at a time; entries live in a single-port-read, single-port-write
// memory whose read data is registered
// add: stores the entry at the end of the table unless it is full; search: scans from
// slot zero for the first matching name (scan reads one entry a cycle) to a hit or the end
// remove: a search, then every later entry is shifted down one slot
// list: one read then one result per entry; empty list gives one result
// rst is synchronous; it empties the table (entry contents are left as they are)
// a stalled result is held in the output register while the next request is accepted
module keyed_table_insert_remove_search (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       req_type,
  input  logic [kt_pkg::KEY_W-1:0]         name_key,
  input  logic [kt_pkg::KEY_W-1:0]         kind_key,
  input  logic signed [kt_pkg::AMT_W-1:0]  amount,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       status,
  output logic [kt_pkg::KEY_W-1:0]         found_name,
  output logic [kt_pkg::KEY_W-1:0]         found_kind,
  output logic signed [kt_pkg::AMT_W-1:0]  found_amount,
  output logic                             last
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_EMIT  = 3'd3;
  localparam logic [2:0] S_LRD   = 3'd4;
  localparam logic [2:0] S_LOUT  = 3'd5;

  logic [2:0]                     state;
  logic [1:0]                     req;
  logic [kt_pkg::KEY_W-1:0]       key_name;
  logic [kt_pkg::CNT_W-1:0]       count;
  logic [kt_pkg::CNT_W-1:0]       idx;
  logic [kt_pkg::CNT_W-1:0]       rd_tag;
  logic [kt_pkg::CNT_W-1:0]       tag_dec;
  logic                           rd_pend;
  logic [1:0]                     res_status;
  kt_pkg::entry_t                 res;

  kt_pkg::entry_t                 mem [kt_pkg::TABLE_DEPTH];
  kt_pkg::entry_t                 rd_data;
  kt_pkg::entry_t                 wr_data;
  kt_pkg::entry_t                 new_entry;
  logic                           rd_en;
  logic                           wr_en;
  logic [kt_pkg::IDX_W-1:0]       rd_addr;
  logic [kt_pkg::IDX_W-1:0]       wr_addr;

  logic                           accept;
  logic                           out_free;
  logic                           hit;
  logic                           more;
  logic                           table_full;
  logic                           load_emit;
  logic                           load_list;

  // handshake and status terms
  assign in_stall   = (state != S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;
  assign hit        = rd_pend && (rd_data.name == key_name);
  assign more       = (idx < count);
  assign table_full = (count >= kt_pkg::CNT_W'(kt_pkg::TABLE_DEPTH));
  assign tag_dec    = rd_tag - kt_pkg::CNT_W'(1);
  assign load_emit  = (state == S_EMIT) && out_free;
  assign load_list  = (state == S_LOUT) && out_free;

  assign new_entry.name   = name_key & kt_pkg::KEY_MASK;
  assign new_entry.kind   = kind_key & kt_pkg::KEY_MASK;
  assign new_entry.amount = amount;

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    wr_en   = 1'b0;
    rd_addr = idx[kt_pkg::IDX_W-1:0];
    wr_addr = count[kt_pkg::IDX_W-1:0];
    wr_data = new_entry;
    case (state)
      S_IDLE: begin
        wr_en = accept && (req_type == kt_pkg::REQ_ADD) && !table_full;
      end
      S_SCAN: begin
        rd_en = !hit && more;
      end
      S_SHIFT: begin
        rd_en   = more;
        wr_en   = rd_pend;
        wr_addr = tag_dec[kt_pkg::IDX_W-1:0];
        wr_data = rd_data;
      end
      S_LRD: begin
        rd_en = 1'b1;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // entry memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      idx       <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load_emit || load_list) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      rd_pend <= rd_en && (state inside {S_SCAN, S_SHIFT});
      if (rd_en) begin
        idx <= idx + kt_pkg::CNT_W'(1);
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            idx <= '0;
            case (req_type)
              kt_pkg::REQ_ADD: begin
                if (!table_full) begin
                  count <= count + kt_pkg::CNT_W'(1);
                end
                state <= S_EMIT;
              end
              kt_pkg::REQ_LIST: begin
                state <= (count == '0) ? S_EMIT : S_LRD;
              end
              default: begin
                state <= S_SCAN;
              end
            endcase
          end
        end
        S_SCAN: begin
          // no read is issued on a hit, so rd_pend clears above
          if (hit) begin
            idx     <= rd_tag + kt_pkg::CNT_W'(1);
            state   <= (req == kt_pkg::REQ_REMOVE) ? S_SHIFT : S_EMIT;
          end else if (!more && !rd_pend) begin
            state <= S_EMIT;
          end
        end
        S_SHIFT: begin
          if (!more && !rd_pend) begin
            count <= count - kt_pkg::CNT_W'(1);
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_LRD: begin
          state <= S_LOUT;
        end
        S_LOUT: begin
          if (out_free) begin
            state <= (idx == count) ? S_IDLE : S_LRD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_tag <= idx;
    end
    if (accept) begin
      req      <= req_type;
      key_name <= name_key & kt_pkg::KEY_MASK;
      res      <= '0;
      case (req_type)
        kt_pkg::REQ_ADD:  res_status <= table_full ? kt_pkg::ST_FULL : kt_pkg::ST_OK;
        kt_pkg::REQ_LIST: res_status <= kt_pkg::ST_EMPTY;
        default:          res_status <= kt_pkg::ST_NOT_FOUND;
      endcase
    end
    if (state == S_SCAN && hit) begin
      res        <= rd_data;
      res_status <= kt_pkg::ST_OK;
    end
    if (load_emit) begin
      status       <= res_status;
      found_name   <= res.name;
      found_kind   <= res.kind;
      found_amount <= res.amount;
      last         <= 1'b1;
    end else if (load_list) begin
      status       <= kt_pkg::ST_OK;
      found_name   <= rd_data.name;
      found_kind   <= rd_data.kind;
      found_amount <= rd_data.amount;
      last         <= (idx == count);
    end
  end

  // entry count stays within the table
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= kt_pkg::CNT_W'(kt_pkg::TABLE_DEPTH))
    else $error("entry count above table depth");

  // count moves by at most one per cycle
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |->
      ((count - $past(count) == kt_pkg::CNT_W'(1)) ||
       ($past(count) - count == kt_pkg::CNT_W'(1))))
    else $error("entry count jumped");

  // memory is written only on add or during the shift
  a_write_owner: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_IDLE || state == S_SHIFT))
    else $error("memory write outside add or shift");

  // a shift never writes below slot zero
  a_shift_tag: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT && rd_pend) |-> (rd_tag != '0))
    else $error("shift source at slot zero");

endmodule

FILE: dv/keyed_table_insert_remove_search_tb.sv
`timescale 1ns / 1ps

module keyed_table_insert_remove_search_tb;
  import kt_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int POOL_SIZE      = 8;
  localparam int MAX_PRINTS     = 40;

  // one expected result transaction
  typedef struct {
    logic [1:0]              status;
    logic [KEY_W-1:0]        name;
    logic [KEY_W-1:0]        kind;
    logic signed [AMT_W-1:0] amount;
    logic                    last;
  } reply_t;

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_stall;
  logic [1:0]              req_type;
  logic [KEY_W-1:0]        name_key;
  logic [KEY_W-1:0]        kind_key;
  logic signed [AMT_W-1:0] amount;
  logic                    out_valid;
  logic                    out_stall;
  logic [1:0]              status;
  logic [KEY_W-1:0]        found_name;
  logic [KEY_W-1:0]        found_kind;
  logic signed [AMT_W-1:0] found_amount;
  logic                    last;

  // shadow copy of the table and the replies it predicts
  entry_t           shadow_entries [TABLE_DEPTH];
  int               shadow_count;
  reply_t           pending_replies [$];
  logic [KEY_W-1:0] name_pool [POOL_SIZE];
  bit               pool_ready;

  int send_idle_pct;
  int recv_stall_pct;
  int mismatch_count;
  int results_checked;
  int idle_cycles;
  int req_counts [4];
  int full_hits;
  int empty_lists;
  reply_t want;

  keyed_table_insert_remove_search uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .name_key     (name_key),
    .kind_key     (kind_key),
    .amount       (amount),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .found_name   (found_name),
    .found_kind   (found_kind),
    .found_amount (found_amount),
    .last         (last)
  );

  // clock
  always #5 clk = ~clk;

  // receiver back-pressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] exp_val);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS)
      $display("mismatch: %s at result %0d, got %h, expected %h", field,
               results_checked, got, exp_val);
  endtask

  task automatic push_reply(input logic [1:0] st, input logic [KEY_W-1:0] nm,
                            input logic [KEY_W-1:0] kd,
                            input logic signed [AMT_W-1:0] am, input logic lst);
    reply_t r;
    r.status = st;
    r.name   = nm;
    r.kind   = kd;
    r.amount = am;
    r.last   = lst;
    pending_replies.push_back(r);
  endtask

  // update the shadow table for one accepted request and queue its replies
  task automatic predict_request(input logic [1:0] req, input logic [KEY_W-1:0] nm_in,
                                 input logic [KEY_W-1:0] kd_in,
                                 input logic signed [AMT_W-1:0] am);
    logic [KEY_W-1:0] nm;
    logic [KEY_W-1:0] kd;
    int hit;
    nm = nm_in & KEY_MASK;
    kd = kd_in & KEY_MASK;
    hit = -1;
    case (req)
      REQ_ADD: begin
        if (shadow_count >= TABLE_DEPTH) begin
          full_hits++;
          push_reply(ST_FULL, '0, '0, '0, 1'b1);
        end else begin
          shadow_entries[shadow_count].name   = nm;
          shadow_entries[shadow_count].kind   = kd;
          shadow_entries[shadow_count].amount = am;
          shadow_count++;
          push_reply(ST_OK, '0, '0, '0, 1'b1);
        end
      end
      REQ_LIST: begin
        if (shadow_count == 0) begin
          empty_lists++;
          push_reply(ST_EMPTY, '0, '0, '0, 1'b1);
        end else begin
          for (int i = 0; i < shadow_count; i++)
            push_reply(ST_OK, shadow_entries[i].name, shadow_entries[i].kind,
                       shadow_entries[i].amount, (i == shadow_count - 1));
        end
      end
      default: begin
        // remove and search share the first-match lookup
        for (int i = 0; i < shadow_count; i++)
          if (hit < 0 && shadow_entries[i].name == nm) hit = i;
        if (hit < 0) begin
          push_reply(ST_NOT_FOUND, '0, '0, '0, 1'b1);
        end else begin
          push_reply(ST_OK, shadow_entries[hit].name, shadow_entries[hit].kind,
                     shadow_entries[hit].amount, 1'b1);
          if (req == REQ_REMOVE) begin
            for (int i = hit; i + 1 < shadow_count; i++)
              shadow_entries[i] = shadow_entries[i + 1];
            shadow_count--;
          end
        end
      end
    endcase
  endtask

  // drive one request transaction; entered and left at a falling edge
  task automatic send_request(input logic [1:0] req, input logic [KEY_W-1:0] nm,
                              input logic [KEY_W-1:0] kd,
                              input logic signed [AMT_W-1:0] am);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    name_key <= nm;
    kind_key <= kd;
    amount   <= am;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predict_request(req, nm, kd, am);
    req_counts[req]++;
    @(negedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("result with nothing pending", {62'd0, status}, 64'd0);
      end else begin
        want = pending_replies.pop_front();
        if (status !== want.status)
          report_mismatch("status", {62'd0, status}, {62'd0, want.status});
        if (found_name !== want.name) report_mismatch("found_name", found_name, want.name);
        if (found_kind !== want.kind) report_mismatch("found_kind", found_kind, want.kind);
        if (found_amount !== want.amount)
          report_mismatch("found_amount", {32'd0, found_amount}, {32'd0, want.amount});
        if (last !== want.last) report_mismatch("last", {63'd0, last}, {63'd0, want.last});
      end
      results_checked++;
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results pending", pending_replies.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // requests against an empty table
  task automatic test_empty_table();
    send_request(REQ_LIST, '0, '0, '0);
    send_request(REQ_REMOVE, 64'h0000_0000_0041_4243, rand64(), $urandom);
    send_request(REQ_SEARCH, '0, '1, 32'sh8000_0000);
  endtask

  // fill every slot with extreme field values, then overflow and list the table
  task automatic test_fill_to_full();
    send_request(REQ_ADD, 64'h0, 64'hffff_ffff_ffff_ffff, 32'sh8000_0000);
    send_request(REQ_ADD, 64'hffff_ffff_ffff_ffff, 64'h0, 32'sh7fff_ffff);
    send_request(REQ_ADD, 64'h8000_0000_0000_0001, 64'h0000_0000_6d65_6469, 32'sd0);
    send_request(REQ_ADD, 64'h0000_0000_616d_6d6f, 64'h5555_5555_5555_5555, -32'sd1);
    send_request(REQ_ADD, 64'h8000_0000_0000_0001, 64'haaaa_aaaa_aaaa_aaaa, 32'sd5);
    send_request(REQ_ADD, 64'h0000_0000_0000_0041, 64'h0102_0304_0506_0708, 32'sd1);
    send_request(REQ_ADD, 64'h4142_4344_4546_4748, 64'h0000_0000_0000_00ff, 32'sd2);
    send_request(REQ_ADD, 64'h7fff_ffff_ffff_fffe, 64'h8000_0000_0000_0000, 32'sd3);
    send_request(REQ_ADD, 64'h0000_0000_0000_0001, 64'hffff_ffff_0000_0000, 32'sh5555_5555);
    send_request(REQ_ADD, 64'h1234_5678_9abc_def0, 64'h0fed_cba9_8765_4321, 32'shaaaa_aaaa);
    send_request(REQ_ADD, 64'h0000_0000_0000_0002, 64'h1, 32'sd9);
    send_request(REQ_LIST, '0, '0, '0);
  endtask

  // first match among duplicates, plus a one-bit near miss
  task automatic test_lookup();
    send_request(REQ_SEARCH, 64'hffff_ffff_ffff_ffff, '0, '0);
    send_request(REQ_SEARCH, 64'h8000_0000_0000_0001, '0, '0);
    send_request(REQ_SEARCH, 64'h8000_0000_0000_0000, '0, '0);
  endtask

  // remove at the head, the tail and in the middle, then a miss, a list and a search
  task automatic test_remove();
    send_request(REQ_REMOVE, 64'h0, '0, '0);
    send_request(REQ_REMOVE, 64'h1234_5678_9abc_def0, '0, '0);
    send_request(REQ_REMOVE, 64'h8000_0000_0000_0001, '0, '0);
    send_request(REQ_REMOVE, 64'h0000_0000_0000_0002, '0, '0);
    send_request(REQ_LIST, '0, '0, '0);
    send_request(REQ_SEARCH, 64'h8000_0000_0000_0001, '0, '0);
  endtask

  // random traffic over a small name pool so hits and duplicates are common
  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int num_items);
    int add_w;
    int pick;
    logic [1:0] req;
    logic [KEY_W-1:0] nm;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    // seed the pool with names already in the table so they can drain
    if (!pool_ready) begin
      for (int i = 0; i < POOL_SIZE; i++)
        name_pool[i] = (i < shadow_count && i < 4) ? shadow_entries[i].name : rand64();
      pool_ready = 1'b1;
    end
    for (int n = 0; n < num_items; n++) begin
      if (shadow_count <= 2) add_w = 60;
      else if (shadow_count >= TABLE_DEPTH - 1) add_w = 20;
      else add_w = 40;
      pick = $urandom_range(0, 99);
      if (pick < add_w) begin
        req = REQ_ADD;
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 4) req = REQ_REMOVE;
        else if (pick < 8) req = REQ_SEARCH;
        else req = REQ_LIST;
      end
      pick = $urandom_range(0, 99);
      nm = name_pool[$urandom_range(0, POOL_SIZE - 1)];
      if (req == REQ_ADD) begin
        if (pick >= 85) nm = rand64();
      end else if (pick >= 85) begin
        nm = rand64();
      end else if (pick >= 70) begin
        nm = nm ^ (64'd1 << $urandom_range(0, 63));
      end
      send_request(req, nm, rand64(), $urandom);
    end
  endtask

  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    in_valid       = 1'b0;
    req_type       = REQ_ADD;
    name_key       = '0;
    kind_key       = '0;
    amount         = '0;
    out_stall      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    shadow_count   = 0;
    pool_ready     = 1'b0;
    mismatch_count = 0;
    idle_cycles    = 0;
    full_hits      = 0;
    empty_lists    = 0;
    results_checked = 0;
    for (int i = 0; i < 4; i++) req_counts[i] = 0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_fill_to_full();
    test_lookup();
    test_remove();
    test_random_traffic(0, 0, 77);
    test_random_traffic(75, 0, 77);
    test_random_traffic(0, 75, 77);
    test_random_traffic(32, 32, 77);
    in_valid <= 1'b0;

    // drain outstanding replies, then watch for strays
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("run covered %0d requests: %0d add, %0d remove, %0d list, %0d search",
             req_counts[REQ_ADD] + req_counts[REQ_REMOVE] + req_counts[REQ_LIST] +
             req_counts[REQ_SEARCH], req_counts[REQ_ADD], req_counts[REQ_REMOVE],
             req_counts[REQ_LIST], req_counts[REQ_SEARCH]);
    $display("%0d results checked, %0d adds on a full table, %0d lists of an empty table",
             results_checked, full_hits, empty_lists);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
